FILE: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/ucbs_pkg.sv
`default_nettype none
package ucbs_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int LANE_STAGES    = 5;

    localparam int PT_W  = 16;
    localparam int T_W   = 17;
    localparam int OUT_W = 24;
    localparam int CNT_W = 9;
    localparam int SW_W  = 8;

    localparam int C3_W = 20;
    localparam int C2_W = 22;
    localparam int C1_W = 22;
    localparam int C0_W = 20;
    localparam int E_W  = 11;

    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    localparam logic signed [31:0] OUT_MAX     = 32'sd8388607;
    localparam logic signed [31:0] OUT_MIN     = -32'sd8388608;
    localparam logic [31:0]        DIV3_RECIP  = 32'hAAAAAAAB;
    localparam logic signed [31:0] DIV_BIAS    = 32'sd805306368;
    localparam logic signed [31:0] DIV_OFFSET  = 32'sd268435456;

    localparam logic [0:0] REG_POINT_COUNT  = 1'b0;
    localparam logic [0:0] REG_STROKE_WIDTH = 1'b1;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_EVAL  = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        MODE_EMPTY,
        MODE_ONE,
        MODE_TWO,
        MODE_THREE,
        MODE_SPLINE
    } mode_t;

    // 6 * value = c3*u^3 + c2*u^2*2^16 + c1*u*2^32 + c0*2^48 + e*2^48, over 6*2^40
    typedef struct packed {
        logic signed [C3_W-1:0] c3;
        logic signed [C2_W-1:0] c2;
        logic signed [C1_W-1:0] c1;
        logic signed [C0_W-1:0] c0;
        logic signed [E_W-1:0]  e;
    } coef_t;

    function automatic coef_t coef_calc(
        input mode_t                  m,
        input logic signed [PT_W-1:0] p0,
        input logic signed [PT_W-1:0] p1,
        input logic signed [PT_W-1:0] p2,
        input logic signed [PT_W-1:0] p3,
        input logic [SW_W-1:0]        s
    );
        logic signed [23:0] a0;
        logic signed [23:0] a1;
        logic signed [23:0] a2;
        logic signed [23:0] a3;
        logic signed [23:0] sv;
        coef_t c;
        a0 = 24'(p0);
        a1 = 24'(p1);
        a2 = 24'(p2);
        a3 = 24'(p3);
        sv = 24'(s);
        c  = '0;
        unique case (m)
            MODE_ONE:
            begin
                c.c1 = C1_W'(-(sv * 6));
                c.c0 = C0_W'(a0 * 6);
                c.e  = E_W'(sv * 3);
            end
            MODE_TWO:
            begin
                c.c1 = C1_W'((a1 - a0) * 6);
                c.c0 = C0_W'(a0 * 6);
            end
            MODE_THREE:
            begin
                c.c2 = C2_W'((a0 - (a1 <<< 1) + a2) * 6);
                c.c1 = C1_W'((a1 - a0) * 12);
                c.c0 = C0_W'(a0 * 6);
            end
            MODE_SPLINE:
            begin
                c.c3 = C3_W'(a3 - a0 + (a1 - a2) * 3);
                c.c2 = C2_W'((a0 + a2) * 3 - a1 * 6);
                c.c1 = C1_W'((a2 - a0) * 3);
                c.c0 = C0_W'(a0 + (a1 <<< 2) + a2);
            end
            default:
            begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/uniform_cubic_bspline_eval.sv
// channel   | handshake                       | payload
// ----------+---------------------------------+------------------------------------------
// config    | cfg_we                          | cfg_index, cfg_data
// request   | in_valid / in_stall             | func, point_index, point_x, point_y, param_t
// result    | out_valid / out_stall           | curve_x, curve_y, empty_res
//
// a point write does not hold the memory; an evaluate holds the single-port point memory
// for four point reads (one point read per cycle while no held result stalls the output),
// so a new evaluate is taken only with the last read of the one before; a result follows
// its evaluate through 4 reads, a coefficient stage and a 5-stage horner/divide lane
// rst_n clears control only; point memory contents are undefined until written
// out_stall on a result freezes sequencer and lanes; writes and one evaluate still enter
`default_nettype none
module uniform_cubic_bspline_eval #(
    parameter int MAX_POINTS = ucbs_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [ucbs_pkg::CNT_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [7:0]                          point_index,
    input  logic signed [ucbs_pkg::PT_W-1:0]    point_x,
    input  logic signed [ucbs_pkg::PT_W-1:0]    point_y,
    input  logic [ucbs_pkg::T_W-1:0]            param_t,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ucbs_pkg::OUT_W-1:0]   curve_x,
    output logic signed [ucbs_pkg::OUT_W-1:0]   curve_y,
    output logic                                empty_res
);
    import ucbs_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int PRW = T_W + CW;
    localparam int LAT = LANE_STAGES + 1;

    logic [CNT_W-1:0] point_count_reg;
    logic [SW_W-1:0]  stroke_width_reg;

    logic [CW-1:0]    n_eff;
    mode_t            mode_n;
    logic [T_W-1:0]   t_c;
    logic [CW-1:0]    n_m3;
    logic [PRW-1:0]   seg_prod;
    logic [CW:0]      seg_full;
    logic [CW:0]      seg_lim;
    logic [AW-1:0]    seg_n;
    logic [T_W-1:0]   u_n;

    logic             en;
    logic             last;
    logic             acc;
    logic             acc_eval;
    logic             acc_wr;
    logic             rd_en;
    logic [AW+7:0]    idx_wide;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;

    logic             busy_reg;
    logic [1:0]       k_reg;
    logic [AW-1:0]    seg_reg;
    logic [T_W-1:0]   u_reg;
    mode_t            mode_reg;
    logic             fin_valid_reg;
    logic [T_W-1:0]   fin_u_reg;
    mode_t            fin_mode_reg;

    logic [2*PT_W-1:0] mem [MAX_POINTS];
    logic [2*PT_W-1:0] rdata_reg;
    logic signed [PT_W-1:0] px_reg [3];
    logic signed [PT_W-1:0] py_reg [3];

    coef_t            cx_reg;
    coef_t            cy_reg;
    logic [T_W-1:0]   cu_reg;
    logic [LAT-1:0]   vld_reg;
    logic [LAT-1:0]   emp_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg  <= '0;
            stroke_width_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINT_COUNT:  point_count_reg  <= cfg_data;
                REG_STROKE_WIDTH: stroke_width_reg <= cfg_data[SW_W-1:0];
                default:          ;
            endcase
        end
    end

    // segment and local parameter
    always_comb
    begin
        if (32'(point_count_reg) > MAX_POINTS)
        begin
            n_eff = CW'(MAX_POINTS);
        end
        else
        begin
            n_eff = CW'(point_count_reg);
        end

        if (n_eff == CW'(0))
        begin
            mode_n = MODE_EMPTY;
        end
        else if (n_eff == CW'(1))
        begin
            mode_n = MODE_ONE;
        end
        else if (n_eff == CW'(2))
        begin
            mode_n = MODE_TWO;
        end
        else if (n_eff == CW'(3))
        begin
            mode_n = MODE_THREE;
        end
        else
        begin
            mode_n = MODE_SPLINE;
        end

        t_c      = (param_t > T_ONE) ? T_ONE : param_t;
        n_m3     = n_eff - CW'(3);
        seg_prod = PRW'(t_c) * PRW'(n_m3);
        seg_full = seg_prod[PRW-1:16];
        seg_lim  = (CW+1)'(n_eff - CW'(4));

        if (mode_n == MODE_SPLINE)
        begin
            if (seg_full > seg_lim)
            begin
                seg_n = seg_lim[AW-1:0];
                u_n   = T_ONE;
            end
            else
            begin
                seg_n = seg_full[AW-1:0];
                u_n   = {1'b0, seg_prod[15:0]};
            end
        end
        else
        begin
            seg_n = '0;
            u_n   = t_c;
        end
    end

    // request handshake
    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign last     = busy_reg && (k_reg == 2'd3) && en;
    assign in_stall = busy_reg && !(last && (func == FUNC_EVAL));
    assign acc      = in_valid && !in_stall;
    assign acc_eval = acc && (func == FUNC_EVAL);
    assign acc_wr   = acc && (func == FUNC_WRITE) && (32'(point_index) < MAX_POINTS);
    assign rd_en    = busy_reg && en;
    assign idx_wide = (AW+8)'(point_index);
    assign waddr    = idx_wide[AW-1:0];
    assign raddr    = seg_reg + AW'(k_reg);

    // read sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                k_reg <= k_reg + 2'd1;
            end
            if (acc_eval)
            begin
                busy_reg <= 1'b1;
            end
            else if (last)
            begin
                busy_reg <= 1'b0;
            end
            if (en)
            begin
                fin_valid_reg <= last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_eval)
        begin
            seg_reg  <= seg_n;
            u_reg    <= u_n;
            mode_reg <= mode_n;
        end
        if (en)
        begin
            fin_u_reg    <= u_reg;
            fin_mode_reg <= mode_reg;
        end
    end

    // point memory, single port
    always_ff @(posedge clk)
    begin
        if (acc_wr)
        begin
            mem[waddr] <= {point_x, point_y};
        end
        else if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en && (k_reg != 2'd0))
        begin
            px_reg[k_reg - 2'd1] <= rdata_reg[2*PT_W-1:PT_W];
            py_reg[k_reg - 2'd1] <= rdata_reg[PT_W-1:0];
        end
    end

    // coefficient stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg <= coef_calc(fin_mode_reg, px_reg[0], px_reg[1], px_reg[2],
                                rdata_reg[2*PT_W-1:PT_W], stroke_width_reg);
            cy_reg <= coef_calc(fin_mode_reg, py_reg[0], py_reg[1], py_reg[2],
                                rdata_reg[PT_W-1:0], '0);
            cu_reg <= fin_u_reg;
            emp_reg <= {emp_reg[LAT-2:0], (fin_mode_reg == MODE_EMPTY)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], fin_valid_reg};
        end
    end

    ucbs_lane u_lane_x (
        .clk    (clk),
        .en     (en),
        .coef   (cx_reg),
        .u      (cu_reg),
        .result (curve_x)
    );

    ucbs_lane u_lane_y (
        .clk    (clk),
        .en     (en),
        .coef   (cy_reg),
        .u      (cu_reg),
        .result (curve_y)
    );

    assign out_valid = vld_reg[LAT-1];
    assign empty_res = emp_reg[LAT-1];

endmodule
`default_nettype wire

FILE: rtl/core/ucbs_lane.sv
`default_nettype none
module ucbs_lane (
    input  logic                                 clk,
    input  logic                                 en,
    input  ucbs_pkg::coef_t                      coef,
    input  logic [ucbs_pkg::T_W-1:0]             u,
    output logic signed [ucbs_pkg::OUT_W-1:0]    result
);
    import ucbs_pkg::*;

    // horner step 1
    logic signed [T_W:0]    us0;
    logic signed [37:0]     m1;
    logic signed [39:0]     h1_next;
    logic signed [39:0]     h1_reg;
    logic signed [C1_W-1:0] c1_1_reg;
    logic signed [C0_W-1:0] c0_1_reg;
    logic signed [E_W-1:0]  e_1_reg;
    logic [T_W-1:0]         u_1_reg;

    // horner step 2
    logic signed [T_W:0]    us1;
    logic signed [57:0]     m2;
    logic signed [59:0]     h2_next;
    logic signed [59:0]     h2_reg;
    logic signed [C0_W-1:0] c0_2_reg;
    logic signed [E_W-1:0]  e_2_reg;
    logic [T_W-1:0]         u_2_reg;

    // horner step 3
    logic signed [T_W:0]    us2;
    logic signed [77:0]     m3;
    logic signed [79:0]     s_next;
    logic signed [79:0]     s_reg;

    // divide by 6 * 2^40
    logic signed [31:0]     q;
    logic signed [31:0]     qq;
    logic [31:0]            v;
    logic [63:0]            prod_next;
    logic [63:0]            prod_reg;
    logic signed [31:0]     q_reg;
    logic                   nz_reg;
    logic                   neg_reg;

    logic signed [31:0]     d;
    logic signed [31:0]     six_d;
    logic signed [31:0]     f;
    logic                   exact;
    logic signed [OUT_W-1:0] result_next;
    logic signed [OUT_W-1:0] result_reg;

    assign us0     = $signed({1'b0, u});
    assign m1      = coef.c3 * us0;
    assign h1_next = 40'(m1) + (40'(coef.c2) <<< 16);

    assign us1     = $signed({1'b0, u_1_reg});
    assign m2      = h1_reg * us1;
    assign h2_next = 60'(m2) + (60'(c1_1_reg) <<< 32);

    assign us2     = $signed({1'b0, u_2_reg});
    assign m3      = h2_reg * us2;
    assign s_next  = 80'(m3) + (80'(c0_2_reg) <<< 48) + (80'(e_2_reg) <<< 48);

    assign q         = s_reg[71:40];
    assign qq        = q >>> 1;
    assign v         = 32'(qq + DIV_BIAS);
    assign prod_next = v * DIV3_RECIP;

    always_comb
    begin
        d     = $signed({1'b0, prod_reg[63:33]}) - DIV_OFFSET;
        six_d = (d <<< 2) + (d <<< 1);
        exact = !nz_reg && (six_d == q_reg);
        f     = d + ((neg_reg && !exact) ? 32'sd1 : 32'sd0);
        if (f > OUT_MAX)
        begin
            result_next = OUT_MAX[OUT_W-1:0];
        end
        else if (f < OUT_MIN)
        begin
            result_next = OUT_MIN[OUT_W-1:0];
        end
        else
        begin
            result_next = f[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg     <= h1_next;
            c1_1_reg   <= coef.c1;
            c0_1_reg   <= coef.c0;
            e_1_reg    <= coef.e;
            u_1_reg    <= u;
            h2_reg     <= h2_next;
            c0_2_reg   <= c0_1_reg;
            e_2_reg    <= e_1_reg;
            u_2_reg    <= u_1_reg;
            s_reg      <= s_next;
            prod_reg   <= prod_next;
            q_reg      <= q;
            nz_reg     <= |s_reg[39:0];
            neg_reg    <= s_reg[79];
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

FILE: rtl/core/ucbs_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ucbs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                func,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [ucbs_pkg::OUT_W-1:0]   curve_x,
    input logic signed [ucbs_pkg::OUT_W-1:0]   curve_y,
    input logic                                empty_res
);
    import ucbs_pkg::*;

    // held result keeps its payload
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(curve_x) && $stable(curve_y) && $stable(empty_res), "result changed under stall")

    // empty stroke gives zero coordinates
    `ASSERT_CLK(a_empty_zero, clk, rst_n, out_valid && empty_res |-> curve_x == '0 && curve_y == '0, "empty result with nonzero coordinates")

    // a point write never blocks the next request
    `ASSERT_CLK(a_write_free, clk, rst_n, in_valid && !in_stall && func == FUNC_WRITE |=> !in_stall, "stall after point write")

    // no result right out of reset
    `ASSERT_NR(a_reset_quiet, clk, $past(!rst_n) |-> !out_valid, "result valid after reset")

endmodule

bind uniform_cubic_bspline_eval ucbs_checker u_ucbs_checker (.*);
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import ucbs_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int NUM_SLOTS   = 256;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               empty;
    } curve_pt_t;

    typedef struct {
        int                 cnt;
        int                 wid;
        func_t              fn;
        logic [7:0]         idx;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [16:0]        t;
        bit                 typed;
        curve_pt_t          want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [CNT_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic func;
    logic [7:0] point_index;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic [T_W-1:0] param_t;
    logic out_valid;
    logic out_stall;
    logic signed [OUT_W-1:0] curve_x;
    logic signed [OUT_W-1:0] curve_y;
    logic empty_res;

    logic signed [15:0] slot_x [NUM_SLOTS];
    logic signed [15:0] slot_y [NUM_SLOTS];
    int stroke_count;
    int stroke_wid;

    curve_pt_t pending_pts[$];
    int errors;
    int idle_cycles;
    int evals_sent;
    int writes_sent;
    int cfg_writes;
    int points_checked;
    bit quiet;
    int stall_left;

    uniform_cubic_bspline_eval u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .point_index(point_index),
        .point_x(point_x),
        .point_y(point_y),
        .param_t(param_t),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .curve_x(curve_x),
        .curve_y(curve_y),
        .empty_res(empty_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [23:0] sat24(input logic signed [95:0] v);
        if (v > 96'sd8388607)
            return 24'sd8388607;
        if (v < -96'sd8388608)
            return -24'sd8388608;
        return v[23:0];
    endfunction

    function automatic logic signed [95:0] bspline_axis(input longint p [4],
                                                        input longint w [4]);
        logic signed [95:0] acc;
        logic signed [95:0] den;
        acc = 0;
        den = 96'sd6 <<< 40;
        for (int k = 0; k < 4; k++)
            acc = acc + 96'(p[k]) * 96'(w[k]);
        return acc / den;
    endfunction

    function automatic curve_pt_t curve_point(input logic [16:0] t_in);
        curve_pt_t r;
        longint n, t, rx, ry, ax, bx, ay, by, prod, seg, u, u2, u3;
        longint w [4];
        longint px [4];
        longint py [4];
        n = (stroke_count > NUM_SLOTS) ? NUM_SLOTS : stroke_count;
        t = (t_in > 17'd65536) ? 65536 : t_in;
        r.empty = 1'b0;
        rx = 0;
        ry = 0;
        if (n == 0)
        begin
            r.x = 0;
            r.y = 0;
            r.empty = 1'b1;
            return r;
        end
        if (n == 1)
        begin
            rx = (longint'(slot_x[0]) * 65536 + (32768 - t) * stroke_wid) / 256;
            ry = longint'(slot_y[0]) * 256;
        end
        else if (n == 2)
        begin
            rx = (longint'(slot_x[0]) * (65536 - t) + longint'(slot_x[1]) * t) / 256;
            ry = (longint'(slot_y[0]) * (65536 - t) + longint'(slot_y[1]) * t) / 256;
        end
        else if (n == 3)
        begin
            ax = longint'(slot_x[0]) - 2 * longint'(slot_x[1]) + slot_x[2];
            bx = 2 * (longint'(slot_x[1]) - slot_x[0]);
            ay = longint'(slot_y[0]) - 2 * longint'(slot_y[1]) + slot_y[2];
            by = 2 * (longint'(slot_y[1]) - slot_y[0]);
            rx = (ax * t * t + bx * t * 65536 + (longint'(slot_x[0]) <<< 32)) / (64'sd1 <<< 24);
            ry = (ay * t * t + by * t * 65536 + (longint'(slot_y[0]) <<< 32)) / (64'sd1 <<< 24);
        end
        else
        begin
            prod = t * (n - 3);
            seg = prod >>> 16;
            u = prod & 64'hFFFF;
            if (seg > n - 4)
            begin
                seg = n - 4;
                u = 65536;
            end
            u2 = u * u;
            u3 = u2 * u;
            w[0] = (65536 - u) * (65536 - u) * (65536 - u);
            w[1] = 3 * u3 - 6 * u2 * 65536 + (64'sd4 <<< 48);
            w[2] = -3 * u3 + 3 * u2 * 65536 + 3 * u * (64'sd1 <<< 32) + (64'sd1 <<< 48);
            w[3] = u3;
            for (int k = 0; k < 4; k++)
            begin
                px[k] = slot_x[seg + k];
                py[k] = slot_y[seg + k];
            end
            r.x = sat24(bspline_axis(px, w));
            r.y = sat24(bspline_axis(py, w));
            return r;
        end
        r.x = sat24(96'(rx));
        r.y = sat24(96'(ry));
        return r;
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 19) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // result check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pts.size() == 0)
            begin
                $error("unexpected result x=%0d y=%0d empty=%0b", curve_x, curve_y, empty_res);
                errors++;
            end
            else
            begin
                curve_pt_t e;
                e = pending_pts.pop_front();
                points_checked++;
                if (curve_x !== e.x)
                begin
                    $error("curve_x expected %0d actual %0d", e.x, curve_x);
                    errors++;
                end
                if (curve_y !== e.y)
                begin
                    $error("curve_y expected %0d actual %0d", e.y, curve_y);
                    errors++;
                end
                if (empty_res !== e.empty)
                begin
                    $error("empty_res expected %0b actual %0b", e.empty, empty_res);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending_pts.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic set_stroke(input int cnt, input int wid);
        in_valid = 1'b0;
        while (pending_pts.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = REG_POINT_COUNT;
        cfg_data = CNT_W'(cnt);
        @(negedge clk);
        cfg_index = REG_STROKE_WIDTH;
        cfg_data = CNT_W'(wid);
        @(negedge clk);
        cfg_we = 1'b0;
        stroke_count = cnt;
        stroke_wid = wid;
        cfg_writes += 2;
    endtask

    task automatic send_request(input stim_row_t r);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        func = r.fn;
        point_index = r.idx;
        point_x = r.px;
        point_y = r.py;
        param_t = r.t;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (r.fn == FUNC_WRITE)
        begin
            slot_x[r.idx] = r.px;
            slot_y[r.idx] = r.py;
            writes_sent++;
        end
        else
        begin
            pending_pts.push_back(r.typed ? r.want : curve_point(r.t));
            evals_sent++;
        end
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_param();
        case ($urandom_range(0, 7))
            0: return 17'd65536;
            1: return 17'd0;
            2: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic stim_row_t mk(input int cnt, input int wid, input func_t fn,
                                     input int idx, input int px, input int py,
                                     input int t);
        stim_row_t r;
        r.cnt = cnt;
        r.wid = wid;
        r.fn = fn;
        r.idx = 8'(idx);
        r.px = 16'(px);
        r.py = 16'(py);
        r.t = 17'(t);
        r.typed = 1'b0;
        r.want = '{x: 0, y: 0, empty: 1'b0};
        return r;
    endfunction

    function automatic stim_row_t mk_typed(input stim_row_t r, input int ex, input int ey,
                                           input bit ee);
        r.typed = 1'b1;
        r.want = '{x: 24'(ex), y: 24'(ey), empty: ee};
        return r;
    endfunction

    initial
    begin
        stim_row_t plan[$];
        stim_row_t r;
        int phase_cnt [9];
        int phase_wid [9];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = 1'b0;
        point_index = '0;
        point_x = '0;
        point_y = '0;
        param_t = '0;
        out_stall = 1'b0;
        stall_left = 0;
        quiet = 1'b0;
        errors = 0;
        idle_cycles = 0;
        evals_sent = 0;
        writes_sent = 0;
        cfg_writes = 0;
        points_checked = 0;
        stroke_count = 0;
        stroke_wid = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty stroke, then extreme points and every curve shape
        plan.push_back(mk_typed(mk(0, 0, FUNC_EVAL, 0, 0, 0, 0), 0, 0, 1'b1));
        plan.push_back(mk_typed(mk(0, 0, FUNC_EVAL, 255, -1, -1, 131071), 0, 0, 1'b1));
        plan.push_back(mk(0, 0, FUNC_WRITE, 0, 32767, -32768, 0));
        plan.push_back(mk(0, 0, FUNC_WRITE, 1, -32768, 32767, 131071));
        plan.push_back(mk(0, 0, FUNC_WRITE, 2, 0, 0, 0));
        plan.push_back(mk(0, 0, FUNC_WRITE, 3, 100, -5, 0));
        plan.push_back(mk_typed(mk(1, 255, FUNC_EVAL, 0, 0, 0, 0), 8388607, -8388608, 1'b0));
        plan.push_back(mk(1, 255, FUNC_EVAL, 0, 0, 0, 65536));
        plan.push_back(mk(1, 255, FUNC_EVAL, 0, 0, 0, 131071));
        plan.push_back(mk(2, 0, FUNC_EVAL, 0, 0, 0, 0));
        plan.push_back(mk(2, 0, FUNC_EVAL, 0, 0, 0, 65536));
        plan.push_back(mk(2, 0, FUNC_EVAL, 0, 0, 0, 32768));
        plan.push_back(mk(3, 0, FUNC_EVAL, 0, 0, 0, 0));
        plan.push_back(mk(3, 0, FUNC_EVAL, 0, 0, 0, 98304));
        plan.push_back(mk(3, 0, FUNC_EVAL, 0, 0, 0, 21845));
        plan.push_back(mk(4, 0, FUNC_EVAL, 0, 0, 0, 0));
        plan.push_back(mk(4, 0, FUNC_EVAL, 0, 0, 0, 65536));
        plan.push_back(mk(4, 0, FUNC_EVAL, 0, 0, 0, 40000));
        plan.push_back(mk(4, 0, FUNC_EVAL, 0, 0, 0, 65535));
        foreach (plan[i])
        begin
            if (plan[i].cnt != stroke_count || plan[i].wid != stroke_wid)
                set_stroke(plan[i].cnt, plan[i].wid);
            send_request(plan[i]);
        end

        // fill every slot so any count can be evaluated
        for (int s = 0; s < NUM_SLOTS; s++)
            send_request(mk(stroke_count, stroke_wid, FUNC_WRITE, s,
                            rand_coord(), rand_coord(), $urandom));

        phase_cnt = '{256, 511, 5, 1, 0, 2, 3, 300, 4};
        phase_wid = '{0, 255, 17, 255, 0, 200, 3, 128, 9};
        for (int ph = 0; ph < 9; ph++)
        begin
            set_stroke(phase_cnt[ph], phase_wid[ph]);
            if (ph == 8)
                quiet = 1'b1;
            for (int k = 0; k < 18; k++)
            begin
                if ($urandom_range(0, 9) < 7)
                    r = mk(stroke_count, stroke_wid, FUNC_EVAL, $urandom, $urandom,
                           $urandom, rand_param());
                else
                    r = mk(stroke_count, stroke_wid, FUNC_WRITE, $urandom,
                           rand_coord(), rand_coord(), $urandom);
                send_request(r);
            end
        end
        in_valid = 1'b0;

        while (pending_pts.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        $display("sent %0d evaluates and %0d point writes, %0d register writes",
                 evals_sent, writes_sent, cfg_writes);
        $display("checked %0d curve points across empty, 1-3 point and spline strokes",
                 points_checked);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

FILE: uniform_cubic_bspline_eval.f
+incdir+rtl/core
rtl/core/ucbs_pkg.sv
rtl/core/ucbs_lane.sv
rtl/core/uniform_cubic_bspline_eval.sv
rtl/core/ucbs_checker.sv
bench/testbench.sv
